// ----- design/pak_pkg.sv -----
// ----------------------------------------------------------------------------
// pak_pkg
// Shared types, constants and a helper function of the pixel alpha keyer.
// ----------------------------------------------------------------------------
package pak_pkg;

    localparam int FRAC_BITS = 10;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int HALF      = ONE / 2;
    localparam int Q_W       = FRAC_BITS + 1;

    localparam int MAX_DIM = 4096;
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;

    localparam int DIV_Q_W   = COORD_W + FRAC_BITS;
    localparam int DIV_R_W   = DIM_W;
    localparam int MAG_W     = DIV_Q_W;
    localparam int VSQ_W     = 2 * MAG_W;
    localparam int VSUM_W    = VSQ_W + 1;
    localparam int SQ_IN_W   = VSUM_W + 1;
    localparam int SQ_OUT_W  = SQ_IN_W / 2;
    localparam int SQ_REM_W  = SQ_OUT_W + 2;
    localparam int CSQ_W     = 2 * Q_W - 1;
    localparam int CSUM_W    = CSQ_W + 2;
    localparam int NUM_W     = SQ_OUT_W + 2;
    localparam int DEN_W     = Q_W;
    localparam int PROD_W    = 2 * Q_W - 1;
    localparam int SCALED_W  = PROD_W + 8;
    localparam int ALPHA_SHIFT = FRAC_BITS + 10;

    localparam int LUMA_WR    = 13933;
    localparam int LUMA_WG    = 46871;
    localparam int LUMA_WB    = 4732;
    localparam int LUMA_RND   = 32768;
    localparam int LUMA_SHIFT = 16;
    localparam int LUMA_W     = Q_W + LUMA_SHIFT;

    localparam int COLOR_STAGES = 4;
    localparam int SD_LEN   = DIV_Q_W + COLOR_STAGES + SQ_OUT_W + 1 + FRAC_BITS + 2;
    localparam int TAP_T    = DIV_Q_W - 1;
    localparam int CRES_LEN = SQ_OUT_W;
    localparam int PF_LEN   = FRAC_BITS;

    localparam int CFG_W   = 24;
    localparam int CFG_A_W = 3;
    localparam logic [CFG_A_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_THRESHOLD = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_SOFTNESS  = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_KEY_COLOR = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_OPACITY   = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_VIG_INNER = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_VIG_OUTER = 3'd6;
    localparam logic [CFG_A_W-1:0] REG_FRAME     = 3'd7;

    typedef enum logic [3:0] {
        MODE_ALPHA        = 4'd0,
        MODE_LUMA_KEY     = 4'd1,
        MODE_INV_LUMA_KEY = 4'd2,
        MODE_LUMA         = 4'd3,
        MODE_INV_LUMA     = 4'd4,
        MODE_CHROMA       = 4'd5,
        MODE_MAX_RGB      = 4'd6,
        MODE_SAT_KEY      = 4'd7,
        MODE_EDGE         = 4'd8,
        MODE_THRESHOLD    = 4'd9,
        MODE_RED          = 4'd10,
        MODE_GREEN        = 4'd11,
        MODE_BLUE         = 4'd12,
        MODE_VIGNETTE     = 4'd13
    } mode_t;

    typedef struct packed {
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
        logic [7:0]         alpha_in;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] line;
    } pix_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] key_alpha;
    } key_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba_t;

    typedef struct packed {
        logic [CSUM_W-1:0] chroma_sum;
        logic [Q_W-1:0]    key_v;
        logic [Q_W-1:0]    direct;
    } color_res_t;

    typedef struct packed {
        logic           fix;
        logic [Q_W-1:0] fix_val;
        logic           use_ramp;
        logic           invert;
        logic [Q_W-1:0] direct;
    } prep_t;

    function automatic logic [Q_W-1:0] chan_q(input logic [7:0] c);
        logic [Q_W-1:0] base;
        logic [Q_W-1:0] y;
        logic [2:0]     corr;
        base = {1'b0, c, 2'b00};
        y    = base + Q_W'(127);
        if (y >= Q_W'(1020))
            corr = 3'd4;
        else if (y >= Q_W'(765))
            corr = 3'd3;
        else if (y >= Q_W'(510))
            corr = 3'd2;
        else if (y >= Q_W'(255))
            corr = 3'd1;
        else
            corr = 3'd0;
        return base + Q_W'(corr);
    endfunction

endpackage

// ----- design/pak_coord_div.sv -----
// ----------------------------------------------------------------------------
// pak_coord_div
// Pipelined restoring divider, one quotient bit per stage, for the
// normalized pixel coordinate.
// ----------------------------------------------------------------------------
module pak_coord_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [pak_pkg::DIV_Q_W-1:0]   dividend,
    input  logic [pak_pkg::DIV_R_W-1:0]   divisor,
    output logic [pak_pkg::DIV_Q_W-1:0]   quotient
);

    localparam int N = pak_pkg::DIV_Q_W;
    localparam int R = pak_pkg::DIV_R_W;

    logic [R-1:0] rem_reg  [0:N-1];
    logic [R-1:0] rem_next [0:N-1];
    logic [N-1:0] dvd_reg  [0:N-1];
    logic [N-1:0] dvd_next [0:N-1];
    logic [N-1:0] quo_reg  [0:N-1];
    logic [N-1:0] quo_next [0:N-1];
    logic [R-1:0] src_rem  [0:N-1];
    logic [N-1:0] src_dvd  [0:N-1];
    logic [N-1:0] src_quo  [0:N-1];

    always_comb
    begin
        src_rem[0] = '0;
        src_dvd[0] = dividend;
        src_quo[0] = '0;
        for (int k = 1; k < N; k++)
        begin
            src_rem[k] = rem_reg[k-1];
            src_dvd[k] = dvd_reg[k-1];
            src_quo[k] = quo_reg[k-1];
        end
    end

    always_comb
    begin
        logic [R:0] trial;
        logic       qbit;
        for (int k = 0; k < N; k++)
        begin
            trial = {src_rem[k], src_dvd[k][N-1]};
            qbit  = (trial >= {1'b0, divisor});
            if (qbit)
                rem_next[k] = R'(trial - {1'b0, divisor});
            else
                rem_next[k] = trial[R-1:0];
            dvd_next[k] = {src_dvd[k][N-2:0], 1'b0};
            quo_next[k] = {src_quo[k][N-2:0], qbit};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k] <= rem_next[k];
                dvd_reg[k] <= dvd_next[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quotient = quo_reg[N-1];

endmodule

// ----- design/pak_isqrt.sv -----
// ----------------------------------------------------------------------------
// pak_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module pak_isqrt (
    input  logic                          clk,
    input  logic                          en,
    input  logic [pak_pkg::SQ_IN_W-1:0]   radicand,
    output logic [pak_pkg::SQ_OUT_W-1:0]  root
);

    localparam int N  = pak_pkg::SQ_OUT_W;
    localparam int W  = pak_pkg::SQ_IN_W;
    localparam int RW = pak_pkg::SQ_REM_W;

    logic [RW-1:0] rem_reg   [0:N-1];
    logic [RW-1:0] rem_next  [0:N-1];
    logic [W-1:0]  val_reg   [0:N-1];
    logic [W-1:0]  val_next  [0:N-1];
    logic [N-1:0]  root_reg  [0:N-1];
    logic [N-1:0]  root_next [0:N-1];
    logic [RW-1:0] src_rem   [0:N-1];
    logic [W-1:0]  src_val   [0:N-1];
    logic [N-1:0]  src_root  [0:N-1];

    always_comb
    begin
        src_rem[0]  = '0;
        src_val[0]  = radicand;
        src_root[0] = '0;
        for (int k = 1; k < N; k++)
        begin
            src_rem[k]  = rem_reg[k-1];
            src_val[k]  = val_reg[k-1];
            src_root[k] = root_reg[k-1];
        end
    end

    always_comb
    begin
        logic [RW+1:0] shifted;
        logic [RW+1:0] trial;
        for (int k = 0; k < N; k++)
        begin
            shifted = {src_rem[k], src_val[k][W-1:W-2]};
            trial   = {2'b00, src_root[k], 2'b01};
            if (shifted >= trial)
            begin
                rem_next[k]  = RW'(shifted - trial);
                root_next[k] = {src_root[k][N-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = shifted[RW-1:0];
                root_next[k] = {src_root[k][N-2:0], 1'b0};
            end
            val_next[k] = {src_val[k][W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                val_reg[k]  <= val_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root = root_reg[N-1];

endmodule

// ----- design/pak_ramp_div.sv -----
// ----------------------------------------------------------------------------
// pak_ramp_div
// Pipelined fraction divider for the soft ramp: num * ONE / den with
// num below den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pak_ramp_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [pak_pkg::DEN_W-1:0]     num,
    input  logic [pak_pkg::DEN_W-1:0]     den,
    output logic [pak_pkg::FRAC_BITS-1:0] quotient
);

    localparam int N = pak_pkg::FRAC_BITS;
    localparam int D = pak_pkg::DEN_W;

    logic [D-1:0] rem_reg  [0:N-1];
    logic [D-1:0] rem_next [0:N-1];
    logic [D-1:0] den_reg  [0:N-1];
    logic [N-1:0] quo_reg  [0:N-1];
    logic [N-1:0] quo_next [0:N-1];
    logic [D-1:0] src_rem  [0:N-1];
    logic [D-1:0] src_den  [0:N-1];
    logic [N-1:0] src_quo  [0:N-1];

    always_comb
    begin
        src_rem[0] = num;
        src_den[0] = den;
        src_quo[0] = '0;
        for (int k = 1; k < N; k++)
        begin
            src_rem[k] = rem_reg[k-1];
            src_den[k] = den_reg[k-1];
            src_quo[k] = quo_reg[k-1];
        end
    end

    always_comb
    begin
        logic [D:0] trial;
        logic       qbit;
        for (int k = 0; k < N; k++)
        begin
            trial = {src_rem[k], 1'b0};
            qbit  = (trial >= {1'b0, src_den[k]});
            if (qbit)
                rem_next[k] = D'(trial - {1'b0, src_den[k]});
            else
                rem_next[k] = trial[D-1:0];
            quo_next[k] = {src_quo[k][N-2:0], qbit};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= src_den[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quotient = quo_reg[N-1];

endmodule

// ----- design/pak_color.sv -----
// ----------------------------------------------------------------------------
// pak_color
// Four-stage color datapath: channel scaling, luma, max/min, key color
// distance squares, and the per-mode key value and direct alpha.
// ----------------------------------------------------------------------------
module pak_color (
    input  logic                 clk,
    input  logic                 en,
    input  pak_pkg::rgba_t       rgba,
    input  pak_pkg::mode_t       mode,
    input  logic [23:0]          key_color,
    output pak_pkg::color_res_t  res
);

    localparam int Q = pak_pkg::Q_W;
    localparam int L = pak_pkg::LUMA_W;
    localparam int C = pak_pkg::CSQ_W;

    logic [Q-1:0] s1_r_reg, s1_g_reg, s1_b_reg, s1_a_reg;
    logic [Q-1:0] s1_kr_reg, s1_kg_reg, s1_kb_reg;
    logic [Q-1:0] s1_r_next, s1_g_next, s1_b_next, s1_a_next;
    logic [Q-1:0] s1_kr_next, s1_kg_next, s1_kb_next;

    logic [L-1:0] s2_pr_reg, s2_pg_reg, s2_pb_reg;
    logic [L-1:0] s2_pr_next, s2_pg_next, s2_pb_next;
    logic [Q-1:0] s2_mx_reg, s2_mn_reg, s2_dr_reg, s2_dg_reg, s2_db_reg;
    logic [Q-1:0] s2_mx_next, s2_mn_next, s2_dr_next, s2_dg_next, s2_db_next;
    logic [Q-1:0] s2_r_reg, s2_g_reg, s2_b_reg, s2_a_reg;

    logic [Q-1:0] s3_luma_reg, s3_sat_reg, s3_mx_reg;
    logic [Q-1:0] s3_luma_next, s3_sat_next;
    logic [C-1:0] s3_qr_reg, s3_qg_reg, s3_qb_reg;
    logic [C-1:0] s3_qr_next, s3_qg_next, s3_qb_next;
    logic [Q-1:0] s3_r_reg, s3_g_reg, s3_b_reg, s3_a_reg;

    pak_pkg::color_res_t s4_reg;
    pak_pkg::color_res_t s4_next;

    always_comb
    begin
        s1_r_next  = pak_pkg::chan_q(rgba.red);
        s1_g_next  = pak_pkg::chan_q(rgba.green);
        s1_b_next  = pak_pkg::chan_q(rgba.blue);
        s1_a_next  = pak_pkg::chan_q(rgba.alpha);
        s1_kr_next = pak_pkg::chan_q(key_color[23:16]);
        s1_kg_next = pak_pkg::chan_q(key_color[15:8]);
        s1_kb_next = pak_pkg::chan_q(key_color[7:0]);
    end

    always_comb
    begin
        logic [Q-1:0] mx;
        logic [Q-1:0] mn;
        s2_pr_next = L'(L'(pak_pkg::LUMA_WR) * L'(s1_r_reg));
        s2_pg_next = L'(L'(pak_pkg::LUMA_WG) * L'(s1_g_reg));
        s2_pb_next = L'(L'(pak_pkg::LUMA_WB) * L'(s1_b_reg));
        mx = (s1_r_reg > s1_g_reg) ? s1_r_reg : s1_g_reg;
        mn = (s1_r_reg < s1_g_reg) ? s1_r_reg : s1_g_reg;
        if (s1_b_reg > mx)
            mx = s1_b_reg;
        if (s1_b_reg < mn)
            mn = s1_b_reg;
        s2_mx_next = mx;
        s2_mn_next = mn;
        s2_dr_next = (s1_r_reg >= s1_kr_reg) ? s1_r_reg - s1_kr_reg : s1_kr_reg - s1_r_reg;
        s2_dg_next = (s1_g_reg >= s1_kg_reg) ? s1_g_reg - s1_kg_reg : s1_kg_reg - s1_g_reg;
        s2_db_next = (s1_b_reg >= s1_kb_reg) ? s1_b_reg - s1_kb_reg : s1_kb_reg - s1_b_reg;
    end

    always_comb
    begin
        logic [L-1:0] lsum;
        lsum = s2_pr_reg + s2_pg_reg + s2_pb_reg + L'(pak_pkg::LUMA_RND);
        s3_luma_next = Q'(lsum >> pak_pkg::LUMA_SHIFT);
        s3_sat_next  = s2_mx_reg - s2_mn_reg;
        s3_qr_next   = C'(C'(s2_dr_reg) * C'(s2_dr_reg));
        s3_qg_next   = C'(C'(s2_dg_reg) * C'(s2_dg_reg));
        s3_qb_next   = C'(C'(s2_db_reg) * C'(s2_db_reg));
    end

    always_comb
    begin
        s4_next.chroma_sum = pak_pkg::CSUM_W'(s3_qr_reg) + pak_pkg::CSUM_W'(s3_qg_reg)
                           + pak_pkg::CSUM_W'(s3_qb_reg);
        s4_next.key_v = (mode == pak_pkg::MODE_SAT_KEY) ? s3_sat_reg : s3_luma_reg;
        unique case (mode)
            pak_pkg::MODE_ALPHA:     s4_next.direct = s3_a_reg;
            pak_pkg::MODE_LUMA:      s4_next.direct = s3_luma_reg;
            pak_pkg::MODE_INV_LUMA:  s4_next.direct = Q'(pak_pkg::ONE) - s3_luma_reg;
            pak_pkg::MODE_MAX_RGB:   s4_next.direct = s3_mx_reg;
            pak_pkg::MODE_THRESHOLD: s4_next.direct =
                (s3_luma_reg >= Q'(pak_pkg::HALF)) ? Q'(pak_pkg::ONE) : '0;
            pak_pkg::MODE_RED:       s4_next.direct = s3_r_reg;
            pak_pkg::MODE_GREEN:     s4_next.direct = s3_g_reg;
            pak_pkg::MODE_BLUE:      s4_next.direct = s3_b_reg;
            default:                 s4_next.direct = Q'(pak_pkg::ONE);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_r_reg    <= s1_r_next;
            s1_g_reg    <= s1_g_next;
            s1_b_reg    <= s1_b_next;
            s1_a_reg    <= s1_a_next;
            s1_kr_reg   <= s1_kr_next;
            s1_kg_reg   <= s1_kg_next;
            s1_kb_reg   <= s1_kb_next;
            s2_pr_reg   <= s2_pr_next;
            s2_pg_reg   <= s2_pg_next;
            s2_pb_reg   <= s2_pb_next;
            s2_mx_reg   <= s2_mx_next;
            s2_mn_reg   <= s2_mn_next;
            s2_dr_reg   <= s2_dr_next;
            s2_dg_reg   <= s2_dg_next;
            s2_db_reg   <= s2_db_next;
            s2_r_reg    <= s1_r_reg;
            s2_g_reg    <= s1_g_reg;
            s2_b_reg    <= s1_b_reg;
            s2_a_reg    <= s1_a_reg;
            s3_luma_reg <= s3_luma_next;
            s3_sat_reg  <= s3_sat_next;
            s3_mx_reg   <= s2_mx_reg;
            s3_qr_reg   <= s3_qr_next;
            s3_qg_reg   <= s3_qg_next;
            s3_qb_reg   <= s3_qb_next;
            s3_r_reg    <= s2_r_reg;
            s3_g_reg    <= s2_g_reg;
            s3_b_reg    <= s2_b_reg;
            s3_a_reg    <= s2_a_reg;
            s4_reg      <= s4_next;
        end
    end

    assign res = s4_reg;

endmodule

// ----- design/pak_vig.sv -----
// ----------------------------------------------------------------------------
// pak_vig
// Four-stage vignette distance datapath: centered coordinates, magnitudes,
// squares and their sum.
// ----------------------------------------------------------------------------
module pak_vig (
    input  logic                         clk,
    input  logic                         en,
    input  logic [pak_pkg::DIV_Q_W-1:0]  qx,
    input  logic [pak_pkg::DIV_Q_W-1:0]  qy,
    output logic [pak_pkg::VSUM_W-1:0]   dist_sq
);

    localparam int CW = pak_pkg::DIV_Q_W + 1;
    localparam int M  = pak_pkg::MAG_W;
    localparam int S  = pak_pkg::VSQ_W;
    localparam int V  = pak_pkg::VSUM_W;

    logic [CW-1:0] cx_reg, cy_reg, cx_next, cy_next;
    logic [M-1:0]  mx_reg, my_reg, mx_next, my_next;
    logic [S-1:0]  sx_reg, sy_reg, sx_next, sy_next;
    logic [V-1:0]  sum_reg, sum_next;

    always_comb
    begin
        cx_next  = CW'(qx) - CW'(pak_pkg::HALF);
        cy_next  = CW'(qy) - CW'(pak_pkg::HALF);
        mx_next  = cx_reg[CW-1] ? M'(-cx_reg) : cx_reg[M-1:0];
        my_next  = cy_reg[CW-1] ? M'(-cy_reg) : cy_reg[M-1:0];
        sx_next  = S'(mx_reg) * S'(mx_reg);
        sy_next  = S'(my_reg) * S'(my_reg);
        sum_next = V'(sx_reg) + V'(sy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            mx_reg  <= mx_next;
            my_reg  <= my_next;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            sum_reg <= sum_next;
        end
    end

    assign dist_sq = sum_reg;

endmodule

// ----- design/pixel_alpha_keyer.sv -----
// ----------------------------------------------------------------------------
// pixel_alpha_keyer
// Per-pixel alpha keyer: returns each RGBA pixel with an alpha chosen by the
// keying mode and scaled by opacity.
//
// Pixels enter on pix (pix_valid / pix_stall) and leave on key_pix
// (key_valid / key_stall). A transaction completes at a rising edge with
// valid high and stall low. Configuration registers are written through
// cfg_we / cfg_index / cfg_data; the user must do so only while no pixel
// is in flight, which the block itself does not enforce. Throughput: one
// pixel per clock, sustained while the receiver does not stall. The
// pipeline consists of the coordinate divider (22 stages), the color and
// distance stages (4), the square root (23 stages), the ramp setup (1), the
// ramp divider (10 stages), the opacity scaling (2) and the output register.
// Reset clears all valid bits and loads the register defaults; no pixel is
// in flight after reset. When the receiver stalls, the output register
// holds its transaction and one more pixel drops into a skid register; the
// pipeline then freezes and pix_stall rises until the skid register drains.
// ----------------------------------------------------------------------------
module pixel_alpha_keyer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pix_valid,
    output logic                          pix_stall,
    input  pak_pkg::pix_t                 pix,
    output logic                          key_valid,
    input  logic                          key_stall,
    output pak_pkg::key_t                 key_pix,
    input  logic                          cfg_we,
    input  logic [pak_pkg::CFG_A_W-1:0]   cfg_index,
    input  logic [pak_pkg::CFG_W-1:0]     cfg_data
);

    localparam int Q  = pak_pkg::Q_W;
    localparam int NW = pak_pkg::NUM_W;
    localparam int DW = pak_pkg::DEN_W;
    localparam int DM = pak_pkg::DIM_W;
    localparam int CO = pak_pkg::COORD_W;
    localparam int SL = pak_pkg::SD_LEN;
    localparam int CL = pak_pkg::CRES_LEN;
    localparam int PL = pak_pkg::PF_LEN;

    pak_pkg::mode_t keying_mode_reg;
    logic [9:0]     ramp_threshold_reg;
    logic [9:0]     ramp_softness_reg;
    logic [23:0]    key_color_reg;
    logic [10:0]    opacity_reg;
    logic [9:0]     vignette_inner_reg;
    logic [9:0]     vignette_outer_reg;
    logic [23:0]    frame_size_reg;

    logic en;

    logic           in_valid_reg;
    pak_pkg::pix_t  in_pix_reg;

    logic           sd_valid_reg [0:SL-1];
    pak_pkg::rgba_t sd_rgba_reg  [0:SL-1];
    pak_pkg::rgba_t in_rgba;

    logic [DM-1:0] w_full, h_full, w_sat, h_sat;
    logic [CO-1:0] col_sat, row_sat;
    logic [pak_pkg::DIV_Q_W-1:0] x_dvd, y_dvd, qx, qy;

    pak_pkg::color_res_t cres;
    pak_pkg::color_res_t cres_reg [0:CL-1];
    logic [pak_pkg::VSUM_W-1:0]  vsum;
    logic [pak_pkg::SQ_IN_W-1:0] sq_in;
    logic [pak_pkg::SQ_OUT_W-1:0] dist_root;

    pak_pkg::prep_t prep_reg, prep_next;
    logic [DW-1:0]  prep_num_reg, prep_num_next;
    logic [DW-1:0]  prep_den_reg, prep_den_next;
    pak_pkg::prep_t pf_reg [0:PL-1];
    logic [pak_pkg::FRAC_BITS-1:0] ramp_q;

    logic [Q-1:0]  op_sat;
    logic [pak_pkg::PROD_W-1:0] f1_prod_reg, f1_prod_next;
    logic [7:0]    f2_alpha_reg, f2_alpha_next;

    pak_pkg::key_t tail;
    logic          emit;
    logic          out_take;
    logic          key_valid_reg;
    pak_pkg::key_t key_pix_reg;
    logic          skid_valid_reg;
    pak_pkg::key_t skid_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keying_mode_reg    <= pak_pkg::MODE_ALPHA;
            ramp_threshold_reg <= 10'd102;
            ramp_softness_reg  <= 10'd102;
            key_color_reg      <= '0;
            opacity_reg        <= 11'd1024;
            vignette_inner_reg <= '0;
            vignette_outer_reg <= 10'd512;
            frame_size_reg     <= 24'hFFFFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pak_pkg::REG_MODE:      keying_mode_reg    <= pak_pkg::mode_t'(cfg_data[3:0]);
                pak_pkg::REG_THRESHOLD: ramp_threshold_reg <= cfg_data[9:0];
                pak_pkg::REG_SOFTNESS:  ramp_softness_reg  <= cfg_data[9:0];
                pak_pkg::REG_KEY_COLOR: key_color_reg      <= cfg_data[23:0];
                pak_pkg::REG_OPACITY:   opacity_reg        <= cfg_data[10:0];
                pak_pkg::REG_VIG_INNER: vignette_inner_reg <= cfg_data[9:0];
                pak_pkg::REG_VIG_OUTER: vignette_outer_reg <= cfg_data[9:0];
                pak_pkg::REG_FRAME:     frame_size_reg     <= cfg_data[23:0];
            endcase
        end
    end

    assign en        = ~skid_valid_reg;
    assign pix_stall = skid_valid_reg;

    // input register and side line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            for (int k = 0; k < SL; k++)
                sd_valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg    <= pix_valid;
            sd_valid_reg[0] <= in_valid_reg;
            for (int k = 1; k < SL; k++)
                sd_valid_reg[k] <= sd_valid_reg[k-1];
        end
    end

    assign in_rgba = '{red: in_pix_reg.red_in, green: in_pix_reg.green_in,
                       blue: in_pix_reg.blue_in, alpha: in_pix_reg.alpha_in};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_pix_reg     <= pix;
            sd_rgba_reg[0] <= in_rgba;
            for (int k = 1; k < SL; k++)
                sd_rgba_reg[k] <= sd_rgba_reg[k-1];
        end
    end

    // coordinate normalization
    always_comb
    begin
        w_full  = {1'b0, frame_size_reg[11:0]} + DM'(1);
        h_full  = {1'b0, frame_size_reg[23:12]} + DM'(1);
        w_sat   = (w_full > DM'(pak_pkg::MAX_DIM)) ? DM'(pak_pkg::MAX_DIM) : w_full;
        h_sat   = (h_full > DM'(pak_pkg::MAX_DIM)) ? DM'(pak_pkg::MAX_DIM) : h_full;
        col_sat = ({1'b0, in_pix_reg.column} > DM'(pak_pkg::MAX_DIM - 1))
                ? CO'(pak_pkg::MAX_DIM - 1) : in_pix_reg.column;
        row_sat = ({1'b0, in_pix_reg.line} > DM'(pak_pkg::MAX_DIM - 1))
                ? CO'(pak_pkg::MAX_DIM - 1) : in_pix_reg.line;
        x_dvd   = {col_sat, {pak_pkg::FRAC_BITS{1'b0}}};
        y_dvd   = {row_sat, {pak_pkg::FRAC_BITS{1'b0}}};
    end

    pak_coord_div u_div_x (
        .clk      (clk),
        .en       (en),
        .dividend (x_dvd),
        .divisor  (w_sat),
        .quotient (qx)
    );

    pak_coord_div u_div_y (
        .clk      (clk),
        .en       (en),
        .dividend (y_dvd),
        .divisor  (h_sat),
        .quotient (qy)
    );

    pak_color u_color (
        .clk       (clk),
        .en        (en),
        .rgba      (sd_rgba_reg[pak_pkg::TAP_T]),
        .mode      (keying_mode_reg),
        .key_color (key_color_reg),
        .res       (cres)
    );

    pak_vig u_vig (
        .clk     (clk),
        .en      (en),
        .qx      (qx),
        .qy      (qy),
        .dist_sq (vsum)
    );

    assign sq_in = (keying_mode_reg == pak_pkg::MODE_CHROMA)
                 ? pak_pkg::SQ_IN_W'(cres.chroma_sum) : pak_pkg::SQ_IN_W'(vsum);

    pak_isqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (sq_in),
        .root     (dist_root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cres_reg[0] <= cres;
            for (int k = 1; k < CL; k++)
                cres_reg[k] <= cres_reg[k-1];
        end
    end

    // ramp setup
    always_comb
    begin
        logic               is_vig;
        logic               is_keyed;
        logic signed [NW-1:0] num;
        logic [DW:0]        den_s;
        logic [DW-1:0]      den;
        logic [NW-1:0]      v;
        is_vig   = (keying_mode_reg == pak_pkg::MODE_VIGNETTE);
        is_keyed = (keying_mode_reg == pak_pkg::MODE_LUMA_KEY)
                || (keying_mode_reg == pak_pkg::MODE_INV_LUMA_KEY)
                || (keying_mode_reg == pak_pkg::MODE_CHROMA)
                || (keying_mode_reg == pak_pkg::MODE_SAT_KEY);
        v = ((keying_mode_reg == pak_pkg::MODE_CHROMA) || is_vig)
          ? NW'(dist_root) : NW'(cres_reg[CL-1].key_v);
        if (is_vig)
        begin
            num   = NW'(dist_root) - NW'(vignette_inner_reg);
            den_s = (DW+1)'(vignette_outer_reg) - (DW+1)'(vignette_inner_reg) + (DW+1)'(1);
        end
        else
        begin
            num   = v - NW'(ramp_threshold_reg) + NW'(ramp_softness_reg);
            den_s = (DW+1)'({ramp_softness_reg, 1'b1});
        end
        if (den_s[DW])
        begin
            num = -num;
            den = DW'(-den_s);
        end
        else
            den = den_s[DW-1:0];

        prep_next.use_ramp = is_keyed || is_vig;
        prep_next.invert   = is_vig || (keying_mode_reg == pak_pkg::MODE_INV_LUMA_KEY);
        prep_next.direct   = cres_reg[CL-1].direct;
        prep_next.fix      = 1'b1;
        prep_next.fix_val  = '0;
        prep_num_next      = '0;
        prep_den_next      = den;
        priority if (den == '0)
            prep_next.fix_val = (num > 0) ? Q'(pak_pkg::ONE) : '0;
        else if (num <= 0)
            prep_next.fix_val = '0;
        else if (num >= $signed(NW'(den)))
            prep_next.fix_val = Q'(pak_pkg::ONE);
        else
        begin
            prep_next.fix = 1'b0;
            prep_num_next = num[DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg     <= prep_next;
            prep_num_reg <= prep_num_next;
            prep_den_reg <= prep_den_next;
            pf_reg[0]    <= prep_reg;
            for (int k = 1; k < PL; k++)
                pf_reg[k] <= pf_reg[k-1];
        end
    end

    pak_ramp_div u_ramp (
        .clk      (clk),
        .en       (en),
        .num      (prep_num_reg),
        .den      (prep_den_reg),
        .quotient (ramp_q)
    );

    // opacity scaling
    assign op_sat = (opacity_reg > Q'(pak_pkg::ONE)) ? Q'(pak_pkg::ONE) : opacity_reg;

    always_comb
    begin
        logic [Q-1:0] rv;
        logic [Q-1:0] ra;
        logic [Q-1:0] alpha;
        logic [pak_pkg::SCALED_W-1:0] scaled;
        logic [pak_pkg::SCALED_W-1:0] a;
        rv    = pf_reg[PL-1].fix ? pf_reg[PL-1].fix_val : Q'(ramp_q);
        ra    = pf_reg[PL-1].invert ? Q'(pak_pkg::ONE) - rv : rv;
        alpha = pf_reg[PL-1].use_ramp ? ra : pf_reg[PL-1].direct;
        f1_prod_next = pak_pkg::PROD_W'(alpha) * pak_pkg::PROD_W'(op_sat);
        scaled = {f1_prod_reg, 8'b0} - pak_pkg::SCALED_W'(f1_prod_reg)
               + pak_pkg::SCALED_W'(1 << (pak_pkg::ALPHA_SHIFT - 1));
        a = scaled >> pak_pkg::ALPHA_SHIFT;
        f2_alpha_next = (a > pak_pkg::SCALED_W'(255)) ? 8'd255 : a[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_prod_reg  <= f1_prod_next;
            f2_alpha_reg <= f2_alpha_next;
        end
    end

    // output register and skid
    assign tail = '{red_out: sd_rgba_reg[SL-1].red, green_out: sd_rgba_reg[SL-1].green,
                    blue_out: sd_rgba_reg[SL-1].blue, key_alpha: f2_alpha_reg};
    assign emit     = en & sd_valid_reg[SL-1];
    assign out_take = ~key_valid_reg | ~key_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                key_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                key_valid_reg <= emit;
        end
        else if (emit)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
            key_pix_reg <= skid_valid_reg ? skid_reg : tail;
        else if (emit)
            skid_reg <= tail;
    end

    assign key_valid = key_valid_reg;
    assign key_pix   = key_pix_reg;

endmodule
